// ===== hw/rtl/mrts_pkg.sv =====
// Shared types and constants for the mean-reversion trade signal block.
package mrts_pkg;

    // Field widths fixed by the interface.
    localparam int PRICE_W  = 32;
    localparam int CASH_W   = 48;
    localparam int SHARE_W  = 32;
    localparam int WSIZE_W  = 7;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 8;

    // Serial divider operand widths: the widest dividend is the cash balance.
    localparam int DIVD_W = CASH_W;
    localparam int DIVS_W = PRICE_W;

    // Trade decision codes.
    localparam logic [ACTION_W-1:0] ACT_KEEP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SELL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CASH = 8'd1;

    // Reset values and saturation limits.
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd20;
    localparam logic [CASH_W-1:0]  CASH_RESET  = 48'd1000000;
    localparam logic [CASH_W-1:0]  CASH_MAX    = {CASH_W{1'b1}};
    localparam logic [SHARE_W-1:0] SHARE_MAX   = {SHARE_W{1'b1}};

    // Request to the shared serial divider.
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    // Response from the shared serial divider.
    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/mrts_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module mrts_div
    import mrts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Iteration control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], ge};
                if (cnt_reg == STEP_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/mrts_ring.sv =====
// Price ring memory with one write port and one registered read port.
module mrts_ring
    import mrts_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PRICE_W-1:0]       wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [PRICE_W-1:0]       rd_data
);

    logic [PRICE_W-1:0] mem [DEPTH];

    // Write the new price into its slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the oldest price every cycle.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/mean_reversion_trade_signal.sv =====
// Top level of the mean-reversion trade signal: sequencer, state and output register.
//
// Usage: one closing price per bar enters on the input channel (in_valid, in_ready,
// close_price). Each bar yields exactly one result transaction on the output channel
// (out_valid, out_ready, action, quantity, window_mean, mean_valid, cash_after,
// shares_after). Registers are written on the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data): index 0 sets window_size, index 1 (initial_cash) loads
// the cash balance; other indexes are ignored.
// The time a bar takes is set by the single serial divider, which produces one
// quotient bit per cycle over 48 bits: one division for the mean and, on a buy, a
// second one for the share count; the first bar after reset has no mean and uses no
// division. in_ready is low while a bar is in progress, so the next bar is accepted
// only once the sequencer has returned to idle.
// The result sits in an output register, so the next bar is accepted while a result
// waits; if the receiver still stalls when the next result is ready, the sequencer
// holds it until the output register drains.
// Reset clears the window, sets window_size to 20, cash to 1000000 and shares to 0.
module mean_reversion_trade_signal
    import mrts_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PRICE_W-1:0]   close_price,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ACTION_W-1:0]  action,
    output logic [SHARE_W-1:0]   quantity,
    output logic [PRICE_W-1:0]   window_mean,
    output logic                 mean_valid,
    output logic [CASH_W-1:0]    cash_after,
    output logic [SHARE_W-1:0]   shares_after,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CASH_W-1:0]    cfg_data
);

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = CNT_W + 1;
    localparam int SUM_W  = PRICE_W + CNT_W;
    localparam int PROD_W = 2 * PRICE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_DECIDE,
        S_MEAN_WAIT,
        S_BUY_DIV,
        S_QTY_WAIT,
        S_BUY_MUL,
        S_BUY_APPLY,
        S_SELL_MUL,
        S_SELL_APPLY,
        S_PUSH,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [WSIZE_W-1:0]   window_size_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CASH_W-1:0]    cash_reg;
    logic [SHARE_W-1:0]   shares_reg;
    logic [PRICE_W-1:0]   price_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 buy_reg;
    logic                 sell_reg;
    logic [PRICE_W-1:0]   mean_reg;
    logic                 valid_reg;
    logic [SHARE_W-1:0]   qty_reg;
    logic [ACTION_W-1:0]  act_reg;
    logic                 out_valid_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic [SHARE_W-1:0]   quantity_reg;
    logic [PRICE_W-1:0]   window_mean_reg;
    logic                 mean_valid_reg;
    logic [CASH_W-1:0]    cash_after_reg;
    logic [SHARE_W-1:0]   shares_after_reg;

    logic [CNT_W-1:0]     eff_win;
    logic                 pop;
    logic [SLOT_W-1:0]    slot_wide;
    logic [IDX_W-1:0]     slot;
    logic [IDX_W-1:0]     head_inc;
    logic [PRICE_W-1:0]   oldest;
    logic [PRICE_W-1:0]   mul_a;
    logic [PRICE_W-1:0]   mul_b;
    logic [SHARE_W-1:0]   room;
    logic [CASH_W:0]      cash_gain;
    logic                 have_mean;
    logic                 buy_ok;
    logic                 sell_ok;
    logic                 out_free;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Shared serial divider for the mean and the share count.
    mrts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Ring of recent prices; the oldest entry is read continuously.
    mrts_ring #(
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == S_PUSH),
        .wr_addr (slot),
        .wr_data (price_reg),
        .rd_addr (head_reg),
        .rd_data (oldest)
    );

    // Effective window size: zero acts as one, oversize values are clamped.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_win = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            eff_win = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_win = CNT_W'(window_size_reg);
        end
    end

    // Ring addressing for the push.
    always_comb
    begin
        pop       = (count_reg >= eff_win);
        slot_wide = SLOT_W'(head_reg) + SLOT_W'(count_reg);
        if (slot_wide >= SLOT_W'(WINDOW_MAX))
        begin
            slot_wide = slot_wide - SLOT_W'(WINDOW_MAX);
        end
        slot     = slot_wide[IDX_W-1:0];
        head_inc = (head_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_BUY_MUL:
            begin
                mul_a = qty_reg;
                mul_b = price_reg;
            end
            S_SELL_MUL:
            begin
                mul_a = shares_reg;
                mul_b = price_reg;
            end
            default:
            begin
                mul_a = price_reg;
                mul_b = PRICE_W'(count_reg);
            end
        endcase
    end

    // Trade decision and holdings arithmetic.
    always_comb
    begin
        have_mean = (count_reg != '0);
        buy_ok    = have_mean && (price_reg != '0) && (cash_reg > CASH_W'(price_reg))
                    && (prod_reg < PROD_W'(sum_reg));
        sell_ok   = have_mean && !buy_ok && (prod_reg > PROD_W'(sum_reg))
                    && (shares_reg != '0);
        room      = SHARE_MAX - shares_reg;
        cash_gain = {1'b0, cash_reg} + {1'b0, prod_reg[CASH_W-1:0]};
        out_free  = !out_valid_reg || out_ready;
    end

    // Divider requests: mean first, then cash over price on a buy.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(sum_reg);
        div_req.divisor  = DIVS_W'(count_reg);
        if (state_reg == S_DECIDE)
        begin
            div_req.start = have_mean;
        end
        else if (state_reg == S_BUY_DIV)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = cash_reg;
            div_req.divisor  = price_reg;
        end
    end

    // Sequencer, architectural state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_size_reg  <= WSIZE_RESET;
            head_reg         <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            cash_reg         <= CASH_RESET;
            shares_reg       <= '0;
            price_reg        <= '0;
            prod_reg         <= '0;
            buy_reg          <= 1'b0;
            sell_reg         <= 1'b0;
            mean_reg         <= '0;
            valid_reg        <= 1'b0;
            qty_reg          <= '0;
            act_reg          <= ACT_KEEP;
            out_valid_reg    <= 1'b0;
            action_reg       <= ACT_KEEP;
            quantity_reg     <= '0;
            window_mean_reg  <= '0;
            mean_valid_reg   <= 1'b0;
            cash_after_reg   <= '0;
            shares_after_reg <= '0;
        end
        else
        begin
            // The output register drains here unless a new result is loaded below.
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_WINDOW_SIZE)
                        begin
                            window_size_reg <= cfg_data[WSIZE_W-1:0];
                        end
                        else if (cfg_index == CFG_INITIAL_CASH)
                        begin
                            cash_reg <= cfg_data;
                        end
                    end
                    if (in_valid)
                    begin
                        price_reg <= close_price;
                        state_reg <= S_SCALE;
                    end
                end

                S_SCALE:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_DECIDE;
                end

                S_DECIDE:
                begin
                    buy_reg   <= buy_ok;
                    sell_reg  <= sell_ok;
                    valid_reg <= have_mean;
                    mean_reg  <= '0;
                    qty_reg   <= '0;
                    act_reg   <= ACT_KEEP;
                    state_reg <= have_mean ? S_MEAN_WAIT : S_PUSH;
                end

                S_MEAN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg <= div_rsp.quotient[PRICE_W-1:0];
                        if (buy_reg)
                        begin
                            act_reg   <= ACT_BUY;
                            state_reg <= S_BUY_DIV;
                        end
                        else if (sell_reg)
                        begin
                            act_reg   <= ACT_SELL;
                            state_reg <= S_SELL_MUL;
                        end
                        else
                        begin
                            state_reg <= S_PUSH;
                        end
                    end
                end

                S_BUY_DIV:
                begin
                    state_reg <= S_QTY_WAIT;
                end

                S_QTY_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // Clamp the share count to what still fits in the holdings.
                        if (div_rsp.quotient > DIVD_W'(room))
                        begin
                            qty_reg <= room;
                        end
                        else
                        begin
                            qty_reg <= div_rsp.quotient[SHARE_W-1:0];
                        end
                        state_reg <= S_BUY_MUL;
                    end
                end

                S_BUY_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_BUY_APPLY;
                end

                S_BUY_APPLY:
                begin
                    cash_reg   <= cash_reg - prod_reg[CASH_W-1:0];
                    shares_reg <= shares_reg + qty_reg;
                    state_reg  <= S_PUSH;
                end

                S_SELL_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_SELL_APPLY;
                end

                S_SELL_APPLY:
                begin
                    // Sale proceeds saturate the cash balance.
                    qty_reg    <= shares_reg;
                    shares_reg <= '0;
                    if ((prod_reg[PROD_W-1:CASH_W] != '0) || cash_gain[CASH_W])
                    begin
                        cash_reg <= CASH_MAX;
                    end
                    else
                    begin
                        cash_reg <= cash_gain[CASH_W-1:0];
                    end
                    state_reg <= S_PUSH;
                end

                S_PUSH:
                begin
                    if (pop)
                    begin
                        sum_reg  <= sum_reg + SUM_W'(price_reg) - SUM_W'(oldest);
                        head_reg <= head_inc;
                    end
                    else
                    begin
                        sum_reg   <= sum_reg + SUM_W'(price_reg);
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        action_reg       <= act_reg;
                        quantity_reg     <= qty_reg;
                        window_mean_reg  <= mean_reg;
                        mean_valid_reg   <= valid_reg;
                        cash_after_reg   <= cash_reg;
                        shares_after_reg <= shares_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign quantity     = quantity_reg;
    assign window_mean  = window_mean_reg;
    assign mean_valid   = mean_valid_reg;
    assign cash_after   = cash_after_reg;
    assign shares_after = shares_after_reg;

    // A bar in progress blocks the next input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // The stored price count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(count_reg) <= WINDOW_MAX))
        else $error("stored price count beyond ring depth");

    // A buy never overflows the holdings and never spends more than the cash held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUY_APPLY) |-> ((qty_reg <= room) && (prod_reg <= PROD_W'(cash_reg))))
        else $error("buy exceeds holdings room or cash");

endmodule
